// ===== design/fixed_frame_crc8_deframer_macros.svh =====
// Assertion macros for the fixed-frame CRC8 deframer checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef FIXED_FRAME_CRC8_DEFRAMER_MACROS_SVH
`define FIXED_FRAME_CRC8_DEFRAMER_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define FCD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcd check failed");

// Next-cycle implication, quiet during reset.
`define FCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcd check failed");

`endif

// ===== design/fcd_pkg.sv =====
// Shared types, constants and the CRC8 step for the fixed-frame deframer.
// No dependencies; used by fcd_parser and the top level.
package fcd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 10;
  localparam int unsigned PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int unsigned RESULT_W      = 152;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] TAIL_BYTE   = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_TOP     = 8'h80;
  localparam logic [7:0] CRC_START   = 8'h00;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  typedef enum logic [0:0] {
    REG_CRC_CHECK_ENABLE = 1'b0,
    REG_TIMEOUT_TICKS    = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_SOF1 = 3'd0,
    PH_SOF2 = 3'd1,
    PH_CMD  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_CNT  = 3'd5,
    PH_TAIL = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_FRAME   = 3'd1,
    ST_CRC     = 3'd2,
    ST_SYNC    = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  typedef struct packed {
    logic        crc_check_enable;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       step;
    logic       is_tick;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_cmd;
    logic [63:0] payload_low;
    logic [15:0] payload_high;
    logic [31:0] crc_error_total;
    logic [31:0] sync_error_total;
  } result_t;

  // One byte through CRC8, MSB first, eight shift steps.
  function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== design/fcd_parser.sv =====
// Frame parser state and its single-step update for one byte or tick.
// Depends on fcd_pkg.
module fcd_parser (
  input  logic             clk,
  input  logic             rst,
  input  fcd_pkg::cfg_t    cfg,
  input  fcd_pkg::item_t   item,
  output fcd_pkg::result_t result
);

  fcd_pkg::phase_t phase, phase_next;
  logic [7:0]  held_cmd, held_cmd_next;
  logic [3:0]  payload_index, payload_index_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [31:0] crc_error_count, crc_error_count_next;
  logic [31:0] sync_error_count, sync_error_count_next;

  logic [7:0]  payload_store [fcd_pkg::PAYLOAD_BYTES];
  logic        store_we;

  fcd_pkg::status_t status;
  logic [15:0] idle_inc;
  logic [3:0]  index_inc;
  logic [fcd_pkg::PAYLOAD_W-1:0] payload_all;
  logic [79:0] payload_out;

  always_comb begin
    phase_next            = phase;
    held_cmd_next         = held_cmd;
    payload_index_next    = payload_index;
    running_crc_next      = running_crc;
    idle_ticks_next       = idle_ticks;
    crc_error_count_next  = crc_error_count;
    sync_error_count_next = sync_error_count;
    store_we              = 1'b0;
    status                = fcd_pkg::ST_NONE;
    idle_inc  = (idle_ticks != fcd_pkg::IDLE_MAX) ? idle_ticks + 16'd1 : idle_ticks;
    index_inc = payload_index + 4'd1;

    if (item.step && item.is_tick) begin
      if (phase != fcd_pkg::PH_SOF1) begin
        if (idle_inc > cfg.timeout_ticks) begin
          sync_error_count_next = sync_error_count + 32'd1;
          status             = fcd_pkg::ST_TIMEOUT;
          phase_next         = fcd_pkg::PH_SOF1;
          payload_index_next = 4'd0;
          running_crc_next   = fcd_pkg::CRC_START;
          idle_ticks_next    = 16'd0;
        end else begin
          idle_ticks_next = idle_inc;
        end
      end
    end else if (item.step) begin
      idle_ticks_next = 16'd0;
      unique case (phase)
        fcd_pkg::PH_SOF1: begin
          if (item.rx_byte == fcd_pkg::SYNC_FIRST) begin
            running_crc_next = fcd_pkg::crc8_step(fcd_pkg::CRC_START, item.rx_byte);
            phase_next       = fcd_pkg::PH_SOF2;
          end
        end
        fcd_pkg::PH_SOF2: begin
          if (item.rx_byte == fcd_pkg::SYNC_SECOND) begin
            running_crc_next = fcd_pkg::crc8_step(running_crc, item.rx_byte);
            phase_next       = fcd_pkg::PH_CMD;
          end else begin
            sync_error_count_next = sync_error_count + 32'd1;
            status             = fcd_pkg::ST_SYNC;
            payload_index_next = 4'd0;
            // a fresh first sync byte opens the next frame at once
            if (item.rx_byte == fcd_pkg::SYNC_FIRST) begin
              running_crc_next = fcd_pkg::crc8_step(fcd_pkg::CRC_START, item.rx_byte);
              phase_next       = fcd_pkg::PH_SOF2;
            end else begin
              running_crc_next = fcd_pkg::CRC_START;
              phase_next       = fcd_pkg::PH_SOF1;
            end
          end
        end
        fcd_pkg::PH_CMD: begin
          held_cmd_next      = item.rx_byte;
          running_crc_next   = fcd_pkg::crc8_step(running_crc, item.rx_byte);
          payload_index_next = 4'd0;
          phase_next         = fcd_pkg::PH_DATA;
        end
        fcd_pkg::PH_DATA: begin
          store_we           = payload_index < 4'(fcd_pkg::PAYLOAD_BYTES);
          running_crc_next   = fcd_pkg::crc8_step(running_crc, item.rx_byte);
          payload_index_next = index_inc;
          if (index_inc >= 4'(fcd_pkg::PAYLOAD_BYTES)) begin
            phase_next = fcd_pkg::PH_CRC;
          end
        end
        fcd_pkg::PH_CRC: begin
          if (cfg.crc_check_enable && (item.rx_byte != running_crc)) begin
            crc_error_count_next = crc_error_count + 32'd1;
            status             = fcd_pkg::ST_CRC;
            phase_next         = fcd_pkg::PH_SOF1;
            payload_index_next = 4'd0;
            running_crc_next   = fcd_pkg::CRC_START;
          end else begin
            phase_next = fcd_pkg::PH_CNT;
          end
        end
        fcd_pkg::PH_CNT: begin
          phase_next = fcd_pkg::PH_TAIL;
        end
        fcd_pkg::PH_TAIL: begin
          if (item.rx_byte == fcd_pkg::TAIL_BYTE) begin
            status = fcd_pkg::ST_FRAME;
          end else begin
            sync_error_count_next = sync_error_count + 32'd1;
            status = fcd_pkg::ST_SYNC;
          end
          phase_next         = fcd_pkg::PH_SOF1;
          payload_index_next = 4'd0;
          running_crc_next   = fcd_pkg::CRC_START;
        end
        default: begin
          phase_next         = fcd_pkg::PH_SOF1;
          payload_index_next = 4'd0;
          running_crc_next   = fcd_pkg::CRC_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= fcd_pkg::PH_SOF1;
      held_cmd         <= 8'd0;
      payload_index    <= 4'd0;
      running_crc      <= fcd_pkg::CRC_START;
      idle_ticks       <= 16'd0;
      crc_error_count  <= 32'd0;
      sync_error_count <= 32'd0;
    end else begin
      phase            <= phase_next;
      held_cmd         <= held_cmd_next;
      payload_index    <= payload_index_next;
      running_crc      <= running_crc_next;
      idle_ticks       <= idle_ticks_next;
      crc_error_count  <= crc_error_count_next;
      sync_error_count <= sync_error_count_next;
    end
  end

  // payload bytes, no reset
  always_ff @(posedge clk) begin
    if (store_we) begin
      payload_store[payload_index] <= item.rx_byte;
    end
  end

  always_comb begin
    payload_all = '0;
    for (int k = 0; k < fcd_pkg::PAYLOAD_BYTES; k++) begin
      payload_all[8*k +: 8] = payload_store[k];
    end
    payload_out = 80'(payload_all);
  end

  always_comb begin
    result.status           = status;
    result.crc_error_total  = crc_error_count_next;
    result.sync_error_total = sync_error_count_next;
    if (status == fcd_pkg::ST_FRAME) begin
      result.frame_cmd    = held_cmd;
      result.payload_low  = payload_out[63:0];
      result.payload_high = payload_out[79:64];
    end else begin
      result.frame_cmd    = 8'd0;
      result.payload_low  = 64'd0;
      result.payload_high = 16'd0;
    end
  end

endmodule

// ===== design/fixed_frame_crc8_deframer.sv =====
// Fixed-frame CRC8 deframer: a received byte or a millisecond tick per
// request; exactly one result per request. The frame is 0x55, 0xAA, command,
// ten payload bytes, CRC8 (poly 0x07, start 0x00, over bytes 0 to 12), a count
// byte that is not checked, and tail 0xFF. Result status: 0 nothing, 1 frame
// complete (command and payload valid, otherwise zero), 2 CRC error, 3 sync or
// tail error, 4 timeout. Error totals wrap at 2^32. One request is taken every
// cycle while the input register is empty or free to advance. A request lands
// in the input register, then the single parse step loads the result register
// as the request advances, and the result register frees itself in the same
// cycle it is read, so the rate is set only by the downstream tready.
// Configuration is always ready and must only be written while no request is
// outstanding. Depends on fcd_pkg and fcd_parser.
module fixed_frame_crc8_deframer (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]   s_axis_tuser,   // [0] req_type (1 = tick)
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,   // [7:0] frame_cmd, [71:8] payload_low,
                                       // [87:72] payload_high,
                                       // [119:88] crc_error_total,
                                       // [151:120] sync_error_total
  output logic [2:0]   m_axis_tuser,   // [2:0] status
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,      // 0 crc_check_enable, 1 timeout_ticks
  input  logic [15:0]  cfg_data
);

  fcd_pkg::cfg_t    cfg;
  fcd_pkg::item_t   item;
  fcd_pkg::result_t result;

  // input register
  logic       in_valid;
  logic       in_tick;
  logic [7:0] in_byte;

  // result register
  logic [fcd_pkg::RESULT_W-1:0] out_data;
  fcd_pkg::status_t             out_status;

  logic out_free;
  logic advance;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_check_enable <= 1'b1;
      cfg.timeout_ticks    <= fcd_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (fcd_pkg::reg_index_t'(cfg_index))
        fcd_pkg::REG_CRC_CHECK_ENABLE: cfg.crc_check_enable <= cfg_data[0];
        fcd_pkg::REG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick <= s_axis_tuser[0];
      in_byte <= s_axis_tdata;
    end
  end

  assign item.step    = advance;
  assign item.is_tick = in_tick;
  assign item.rx_byte = in_byte;

  fcd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= result.status;
      out_data   <= {result.sync_error_total, result.crc_error_total,
                     result.payload_high, result.payload_low, result.frame_cmd};
    end
  end

  assign m_axis_tdata = out_data;
  assign m_axis_tuser = out_status;

endmodule

// ===== design/fcd_checker.sv =====
// Port-level checks for the fixed-frame CRC8 deframer, bound to the top level.
// Depends on fcd_pkg and fixed_frame_crc8_deframer_macros.svh.
`include "fixed_frame_crc8_deframer_macros.svh"

module fcd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  logic frame_done;
  logic status_ok;

  assign frame_done = m_axis_tuser == fcd_pkg::ST_FRAME;
  assign status_ok  = m_axis_tuser == fcd_pkg::ST_NONE || m_axis_tuser == fcd_pkg::ST_FRAME
                   || m_axis_tuser == fcd_pkg::ST_CRC || m_axis_tuser == fcd_pkg::ST_SYNC
                   || m_axis_tuser == fcd_pkg::ST_TIMEOUT;

  // no frame, no command or payload
  `FCD_ASSERT_IMPL(a_no_frame_zero, m_axis_tvalid && !frame_done, m_axis_tdata[87:0] == 88'd0)
  `FCD_ASSERT_IMPL(a_status_range, m_axis_tvalid, status_ok)
  // a stalled result holds
  `FCD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // no result from idle without a request taken into the input register before it
  `FCD_ASSERT_IMPL(a_no_phantom, $rose(m_axis_tvalid),
                   $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind fixed_frame_crc8_deframer fcd_checker u_fcd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
